// File: hdl/quadrature_encoder_position_counter_assert.svh
// Assertion macros for the quadrature encoder position counter.
// Included by the top level; needs no package.
`ifndef QUADRATURE_ENCODER_POSITION_COUNTER_ASSERT_SVH
`define QUADRATURE_ENCODER_POSITION_COUNTER_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define QEPC_ASSERT_NOW(label, clock, reset_n, ante, cons, msg) \
    label: assert property (@(posedge clock) disable iff (!reset_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define QEPC_ASSERT_NEXT(label, clock, reset_n, ante, cons, msg) \
    label: assert property (@(posedge clock) disable iff (!reset_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/qepc_pkg.sv
// Shared constants for the quadrature encoder position counter.
// Used by the channel interfaces and the top level; depends on nothing.
package qepc_pkg;

    localparam int POSITION_WIDTH_DEFAULT = 32;

    localparam int CMD_WIDTH   = 2;
    localparam int TIME_WIDTH  = 32;
    localparam int LIMIT_WIDTH = 32;
    localparam int POS_OUT_WIDTH = 32;
    localparam int MOVE_WIDTH  = 2;
    localparam int STEP_WIDTH  = 16;
    localparam int DEB_WIDTH   = 16;
    localparam int CFG_INDEX_WIDTH = 3;
    localparam int CFG_DATA_WIDTH  = 32;

    typedef logic [CMD_WIDTH-1:0]       cmd_t;
    typedef logic [MOVE_WIDTH-1:0]      move_t;
    typedef logic [CFG_INDEX_WIDTH-1:0] cfg_index_t;

    localparam cmd_t CMD_SAMPLE = 2'd0;
    localparam cmd_t CMD_ARM    = 2'd1;
    localparam cmd_t CMD_SET    = 2'd2;

    localparam move_t MOVE_NONE = 2'd0;
    localparam move_t MOVE_UP   = 2'd1;
    localparam move_t MOVE_DOWN = 2'd2;

    localparam cfg_index_t REG_LOWER_LIMIT  = 3'd0;
    localparam cfg_index_t REG_UPPER_LIMIT  = 3'd1;
    localparam cfg_index_t REG_STEP_MULT    = 3'd2;
    localparam cfg_index_t REG_MULT_ENABLE  = 3'd3;
    localparam cfg_index_t REG_DEBOUNCE_MS  = 3'd4;

    localparam logic [LIMIT_WIDTH-1:0] LOWER_LIMIT_RESET = 32'h8000_0000;
    localparam logic [LIMIT_WIDTH-1:0] UPPER_LIMIT_RESET = 32'h7FFF_FFFF;
    localparam logic [STEP_WIDTH-1:0]  STEP_MULT_RESET   = 16'd1;
    localparam logic [DEB_WIDTH-1:0]   DEBOUNCE_RESET    = 16'd2;

endpackage

// File: hdl/qepc_if.sv
// Valid/ready channel interfaces for the encoder counter: command in, result out.
// Depends on qepc_pkg for field widths.
interface qepc_in_if;
    logic                                       valid;
    logic                                       ready;
    logic [qepc_pkg::CMD_WIDTH-1:0]             command;
    logic                                       clk_level;
    logic                                       data_level;
    logic [qepc_pkg::TIME_WIDTH-1:0]            time_ms;
    logic signed [qepc_pkg::LIMIT_WIDTH-1:0]    new_position;

    modport source (output valid, command, clk_level, data_level, time_ms, new_position,
                    input ready);
    modport sink   (input valid, command, clk_level, data_level, time_ms, new_position,
                    output ready);
endinterface

interface qepc_out_if;
    logic                                       valid;
    logic                                       ready;
    logic signed [qepc_pkg::POS_OUT_WIDTH-1:0]  position;
    logic [qepc_pkg::MOVE_WIDTH-1:0]            movement;

    modport source (output valid, position, movement, input ready);
    modport sink   (input valid, position, movement, output ready);
endinterface

// File: hdl/quadrature_encoder_position_counter.sv
// Quadrature encoder position counter, top level.
// Depends on qepc_pkg, qepc_if.sv and quadrature_encoder_position_counter_assert.svh.
//
// Usage:
//   sample : command beats in (encoder sample, arm mismatch, set position).
//   result : one beat out per command beat: position after the command and
//            a movement code (none, up, down).
//   cfg_*  : register writes (limits, step multiplier, multiplier enable,
//            debounce). Write only while no command beat is in flight.
// The whole update (debounce compare, step add and saturation) sits
// between the command beat and the result register, the only stage, so
// a beat's result is valid in the cycle after it is accepted.
// Throughput: one beat per cycle while each result is drained as it comes.
// Stall: sample.ready stays high while the result register is empty or is
// being drained this cycle, so a new beat enters in the same cycle the old
// result leaves. A held result blocks new beats and stays stable.
// Reset: position 0, last clock level 1, timestamp 0, mismatch disarmed,
// limits at the full 32-bit range, step 1, multiplier off, debounce 2 ms,
// result register empty.
// The stored position is POSITION_WIDTH bits two's complement; the result
// carries its low 32 bits after sign extension.
`include "quadrature_encoder_position_counter_assert.svh"

module quadrature_encoder_position_counter #(
    parameter int POSITION_WIDTH = qepc_pkg::POSITION_WIDTH_DEFAULT
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    qepc_in_if.sink                                sample,
    qepc_out_if.source                             result,
    input  logic                                   cfg_write,
    input  logic [qepc_pkg::CFG_INDEX_WIDTH-1:0]   cfg_index,
    input  logic [qepc_pkg::CFG_DATA_WIDTH-1:0]    cfg_data
);
    import qepc_pkg::*;

    // Compare width: room for the stored position or a limit, plus a step.
    localparam int CW = ((POSITION_WIDTH > LIMIT_WIDTH) ? POSITION_WIDTH : LIMIT_WIDTH) + 2;

    // Configuration
    logic signed [LIMIT_WIDTH-1:0] lower_limit_reg;
    logic signed [LIMIT_WIDTH-1:0] upper_limit_reg;
    logic [STEP_WIDTH-1:0]         step_mult_reg;
    logic                          mult_enable_reg;
    logic [DEB_WIDTH-1:0]          debounce_reg;

    // Counter state
    logic signed [POSITION_WIDTH-1:0] pos_reg, pos_next;
    logic                             last_clk_reg, last_clk_next;
    logic [TIME_WIDTH-1:0]            last_time_reg, last_time_next;
    logic                             armed_reg, armed_next;
    logic                             arm_level_reg, arm_level_next;

    // Result register
    logic                             out_valid_reg, out_valid_next;
    logic signed [POS_OUT_WIDTH-1:0]  out_pos_reg, out_pos_next;
    move_t                            out_move_reg, out_move_next;

    logic in_fire;

    logic signed [CW-1:0] p_w, lo_w, hi_w, m_w, sum_w, diff_w, stepped_w;
    logic signed [CW-1:0] cfg_lo_w, cfg_hi_w, set_w;
    logic signed [CW-1:0] set_clamp_w, cfg_clamp_w;
    logic [TIME_WIDTH-1:0] elapsed;
    logic sample_ok, flip, changed, do_step, step_up;
    logic signed [POSITION_WIDTH-1:0] item_pos;
    logic signed [CW-1:0] item_pos_w;

    // Lower bound first, then upper bound, as in the limit rules.
    function automatic logic signed [CW-1:0] clamp_w(
        input logic signed [CW-1:0] v,
        input logic signed [CW-1:0] lo,
        input logic signed [CW-1:0] hi
    );
        logic signed [CW-1:0] r;
        if (v < lo)
        begin
            r = lo;
        end
        else if (v > hi)
        begin
            r = hi;
        end
        else
        begin
            r = v;
        end
        return r;
    endfunction

    assign in_fire  = sample.valid && sample.ready;

    // Take a new beat whenever the result register is free or draining now.
    assign sample.ready    = !out_valid_reg || result.ready;
    assign result.valid    = out_valid_reg;
    assign result.position = out_pos_reg;
    assign result.movement = out_move_reg;

    // Sign-extend everything into one compare width.
    assign p_w  = {{(CW-POSITION_WIDTH){pos_reg[POSITION_WIDTH-1]}}, pos_reg};
    assign lo_w = {{(CW-LIMIT_WIDTH){lower_limit_reg[LIMIT_WIDTH-1]}}, lower_limit_reg};
    assign hi_w = {{(CW-LIMIT_WIDTH){upper_limit_reg[LIMIT_WIDTH-1]}}, upper_limit_reg};
    assign m_w  = {{(CW-STEP_WIDTH){1'b0}}, step_mult_reg};
    assign sum_w  = p_w + m_w;
    assign diff_w = p_w - m_w;

    // New limits for a limit write; the other limit keeps its value.
    assign cfg_lo_w = (cfg_index == REG_LOWER_LIMIT)
                    ? {{(CW-LIMIT_WIDTH){cfg_data[LIMIT_WIDTH-1]}}, cfg_data[LIMIT_WIDTH-1:0]}
                    : lo_w;
    assign cfg_hi_w = (cfg_index == REG_UPPER_LIMIT)
                    ? {{(CW-LIMIT_WIDTH){cfg_data[LIMIT_WIDTH-1]}}, cfg_data[LIMIT_WIDTH-1:0]}
                    : hi_w;

    assign set_w = {{(CW-LIMIT_WIDTH){sample.new_position[LIMIT_WIDTH-1]}},
                    sample.new_position};

    // Clamped targets for a set command and for a limit write.
    assign set_clamp_w = clamp_w(set_w, lo_w, hi_w);
    assign cfg_clamp_w = clamp_w(p_w, cfg_lo_w, cfg_hi_w);

    // Debounce: elapsed time wraps modulo 2^32.
    assign elapsed   = sample.time_ms - last_time_reg;
    assign sample_ok = (elapsed > {{(TIME_WIDTH-DEB_WIDTH){1'b0}}, debounce_reg});

    // An armed mismatch inverts the edge rule when the clock left the armed level.
    assign flip    = armed_reg && (sample.clk_level != arm_level_reg);
    assign changed = (sample.clk_level != last_clk_reg);
    assign do_step = flip ? !changed : changed;
    assign step_up = (sample.data_level != sample.clk_level);

    // Saturating step. Multiplier mode snaps to the limit when the step
    // would reach or pass it; single steps hold at the limit.
    always_comb
    begin
        stepped_w = p_w;
        if (step_up)
        begin
            if (mult_enable_reg)
            begin
                stepped_w = (sum_w < hi_w) ? sum_w : hi_w;
            end
            else if (p_w < hi_w)
            begin
                stepped_w = p_w + CW'(1);
            end
        end
        else
        begin
            if (mult_enable_reg)
            begin
                stepped_w = (diff_w > lo_w) ? diff_w : lo_w;
            end
            else if (p_w > lo_w)
            begin
                stepped_w = p_w - CW'(1);
            end
        end
    end

    // Item effect on the counter state.
    always_comb
    begin
        item_pos       = pos_reg;
        last_clk_next  = last_clk_reg;
        last_time_next = last_time_reg;
        armed_next     = armed_reg;
        arm_level_next = arm_level_reg;
        out_move_next  = MOVE_NONE;
        case (sample.command)
            CMD_SAMPLE:
            begin
                if (sample_ok)
                begin
                    last_time_next = sample.time_ms;
                    last_clk_next  = sample.clk_level;
                    armed_next     = 1'b0;
                    if (do_step)
                    begin
                        item_pos = stepped_w[POSITION_WIDTH-1:0];
                    end
                    if (item_pos > pos_reg)
                    begin
                        out_move_next = MOVE_UP;
                    end
                    else if (item_pos < pos_reg)
                    begin
                        out_move_next = MOVE_DOWN;
                    end
                end
            end
            CMD_ARM:
            begin
                arm_level_next = sample.clk_level;
                armed_next     = 1'b1;
            end
            CMD_SET:
            begin
                item_pos = set_clamp_w[POSITION_WIDTH-1:0];
            end
            default:
            begin
                item_pos = pos_reg;
            end
        endcase
    end

    assign item_pos_w   = {{(CW-POSITION_WIDTH){item_pos[POSITION_WIDTH-1]}}, item_pos};
    assign out_pos_next = item_pos_w[POS_OUT_WIDTH-1:0];

    // Position: a limit write clamps it, an accepted beat updates it.
    always_comb
    begin
        pos_next = pos_reg;
        if (cfg_write && (cfg_index == REG_LOWER_LIMIT || cfg_index == REG_UPPER_LIMIT))
        begin
            pos_next = cfg_clamp_w[POSITION_WIDTH-1:0];
        end
        else if (in_fire)
        begin
            pos_next = item_pos;
        end
    end

    assign out_valid_next = in_fire || (out_valid_reg && !result.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lower_limit_reg <= LOWER_LIMIT_RESET;
            upper_limit_reg <= UPPER_LIMIT_RESET;
            step_mult_reg   <= STEP_MULT_RESET;
            mult_enable_reg <= 1'b0;
            debounce_reg    <= DEBOUNCE_RESET;
            pos_reg         <= '0;
            last_clk_reg    <= 1'b1;
            last_time_reg   <= '0;
            armed_reg       <= 1'b0;
            arm_level_reg   <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            pos_reg       <= pos_next;
            out_valid_reg <= out_valid_next;
            if (in_fire)
            begin
                last_clk_reg  <= last_clk_next;
                last_time_reg <= last_time_next;
                armed_reg     <= armed_next;
                arm_level_reg <= arm_level_next;
            end
            if (cfg_write)
            begin
                case (cfg_index)
                    REG_LOWER_LIMIT: lower_limit_reg <= cfg_data[LIMIT_WIDTH-1:0];
                    REG_UPPER_LIMIT: upper_limit_reg <= cfg_data[LIMIT_WIDTH-1:0];
                    REG_STEP_MULT:   step_mult_reg   <= cfg_data[STEP_WIDTH-1:0];
                    REG_MULT_ENABLE: mult_enable_reg <= cfg_data[0];
                    REG_DEBOUNCE_MS: debounce_reg    <= cfg_data[DEB_WIDTH-1:0];
                    default:
                    begin
                        // drop writes beyond the register list
                    end
                endcase
            end
        end
    end

    // Result payload: load on every accepted beat, hold otherwise.
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            out_pos_reg  <= out_pos_next;
            out_move_reg <= out_move_next;
        end
    end

    `QEPC_ASSERT_NOW(a_ready_when_empty, clk, rst_n, !out_valid_reg, sample.ready,
        "ready low with empty result register")
    `QEPC_ASSERT_NEXT(a_beat_gives_result, clk, rst_n, in_fire, result.valid,
        "accepted beat produced no result")
    `QEPC_ASSERT_NEXT(a_arm_sets_flag, clk, rst_n, in_fire && sample.command == CMD_ARM,
        armed_reg, "arm command left mismatch disarmed")
    `QEPC_ASSERT_NEXT(a_no_move_off_sample, clk, rst_n,
        in_fire && sample.command != CMD_SAMPLE, result.movement == MOVE_NONE,
        "non-sample command reported movement")

endmodule

// File: verif/quadrature_encoder_position_counter_test.sv
// Self-checking regression for the quadrature encoder position counter.
// Needs qepc_pkg, the qepc_in_if / qepc_out_if channels and the counter RTL.
module quadrature_encoder_position_counter_test;
    import qepc_pkg::*;

    // The package names three commands; the fourth code must be ignored by the block.
    localparam cmd_t CMD_UNUSED       = 2'd3;
    localparam int   CYCLE_LIMIT      = 200000;
    localparam int   LONG_HOLD_CYCLES = 300;
    localparam int   SETTLE_CYCLES    = 4;

    // One command beat as the sender offers it.
    typedef struct {
        cmd_t                           command;
        logic                           clk_level;
        logic                           data_level;
        logic [TIME_WIDTH-1:0]          time_ms;
        logic signed [LIMIT_WIDTH-1:0]  new_position;
    } encoder_cmd_t;

    // One result beat: position after the command and its movement code.
    typedef struct {
        logic signed [POS_OUT_WIDTH-1:0] position;
        move_t                           movement;
    } position_beat_t;

    logic                       clk;
    logic                       rst_n;
    logic                       cfg_write;
    cfg_index_t                 cfg_index;
    logic [CFG_DATA_WIDTH-1:0]  cfg_data;

    qepc_in_if  sample();
    qepc_out_if result();

    quadrature_encoder_position_counter dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .sample    (sample),
        .result    (result),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Command beats waiting to be offered, and positions owed by the block.
    encoder_cmd_t   encoder_items[$];
    position_beat_t expected_positions[$];

    // Predictor copy of the register file.
    longint                 lim_lo;
    longint                 lim_hi;
    logic [STEP_WIDTH-1:0]  step_size;
    logic                   step_scaled;
    logic [DEB_WIDTH-1:0]   hold_ms;

    // Predictor copy of the counter state.
    longint                 track_pos;
    logic                   prev_clk;
    logic [TIME_WIDTH-1:0]  prev_accept_ms;
    logic                   flip_armed;
    logic                   flip_level;

    // Stimulus cursor: running timestamp, encoder clock level and spin direction.
    logic [TIME_WIDTH-1:0]  stim_now;
    logic                   stim_clk;
    logic                   spin_up;

    // Flow control knobs, in percent of cycles.
    int   send_idle_pct;
    int   recv_stall_pct;
    logic want_long_stall;
    logic long_stall_done;
    int   stall_left;

    int   mismatches;
    int   cycle_count;

    // Saturate a position into the configured range, lower bound first.
    // With crossed limits the lower bound wins for values below it.
    function automatic longint clamp_to_range(longint p);
        if (p < lim_lo)
            return lim_lo;
        if (p > lim_hi)
            return lim_hi;
        return p;
    endfunction

    // Advance the predicted counter by one command beat and return the result
    // beat the block owes for it.
    function automatic position_beat_t count_item(encoder_cmd_t c);
        position_beat_t         r;
        longint                 prior;
        longint                 p;
        longint                 stride;
        logic [TIME_WIDTH-1:0]  elapsed;
        logic                   flip;
        logic                   changed;
        prior      = track_pos;
        r.movement = MOVE_NONE;
        case (c.command)
            CMD_SAMPLE:
            begin
                // An armed mismatch only inverts the rule when the clock now
                // differs from the armed level.
                flip    = flip_armed && (c.clk_level != flip_level);
                elapsed = c.time_ms - prev_accept_ms;
                if (elapsed > hold_ms)
                begin
                    changed        = (c.clk_level != prev_clk);
                    prev_accept_ms = c.time_ms;
                    flip_armed     = 1'b0;
                    if (flip ? !changed : changed)
                    begin
                        p      = track_pos;
                        stride = longint'(step_size);
                        // Direction is up when data differs from clock.
                        if (c.data_level != c.clk_level)
                        begin
                            if (step_scaled)
                                p = (p + stride < lim_hi) ? p + stride : lim_hi;
                            else if (p < lim_hi)
                                p = p + 1;
                        end
                        else
                        begin
                            if (step_scaled)
                                p = (p - stride > lim_lo) ? p - stride : lim_lo;
                            else if (p > lim_lo)
                                p = p - 1;
                        end
                        track_pos = p;
                    end
                    prev_clk = c.clk_level;
                    if (track_pos > prior)
                        r.movement = MOVE_UP;
                    else if (track_pos < prior)
                        r.movement = MOVE_DOWN;
                end
            end
            CMD_ARM:
            begin
                flip_level = c.clk_level;
                flip_armed = 1'b1;
            end
            CMD_SET:
                track_pos = clamp_to_range(longint'(c.new_position));
            default:
                ;
        endcase
        r.position = track_pos[POS_OUT_WIDTH-1:0];
        return r;
    endfunction

    function automatic void queue_cmd(cmd_t command, logic clk_level, logic data_level,
                                      logic [TIME_WIDTH-1:0] time_ms,
                                      logic [LIMIT_WIDTH-1:0] new_position);
        encoder_cmd_t c;
        c.command      = command;
        c.clk_level    = clk_level;
        c.data_level   = data_level;
        c.time_ms      = time_ms;
        c.new_position = new_position;
        encoder_items.push_back(c);
    endfunction

    // Write one register and update the predictor at the edge where the block
    // takes the write.
    task automatic write_reg(cfg_index_t idx, logic [CFG_DATA_WIDTH-1:0] value);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_write <= 1'b0;
        case (idx)
            REG_LOWER_LIMIT:
            begin
                lim_lo    = longint'($signed(value));
                track_pos = clamp_to_range(track_pos);
            end
            REG_UPPER_LIMIT:
            begin
                lim_hi    = longint'($signed(value));
                track_pos = clamp_to_range(track_pos);
            end
            REG_STEP_MULT:   step_size   = value[STEP_WIDTH-1:0];
            REG_MULT_ENABLE: step_scaled = value[0];
            REG_DEBOUNCE_MS: hold_ms     = value[DEB_WIDTH-1:0];
            default:         ;
        endcase
    endtask

    task automatic apply_settings(logic [31:0] lo, logic [31:0] hi, logic [15:0] step,
                                  logic en, logic [15:0] deb);
        write_reg(REG_LOWER_LIMIT, lo);
        write_reg(REG_UPPER_LIMIT, hi);
        write_reg(REG_STEP_MULT, {16'd0, step});
        write_reg(REG_MULT_ENABLE, {31'd0, en});
        write_reg(REG_DEBOUNCE_MS, {16'd0, deb});
    endtask

    // Draw a register setting: full range, narrow ranges around zero or at
    // either end of the 32-bit span, random and crossed limits; steps of
    // zero, one, the maximum or random; debounce from zero to the maximum.
    task automatic pick_random_settings();
        logic [31:0] lo;
        logic [31:0] hi;
        logic [31:0] span;
        logic [15:0] step;
        logic [15:0] deb;
        logic        en;
        case ($urandom_range(4))
            0:
            begin
                lo = LOWER_LIMIT_RESET;
                hi = UPPER_LIMIT_RESET;
            end
            1:
            begin
                span = $urandom_range(1000);
                lo   = -span;
                hi   = span;
            end
            2:
            begin
                lo = $urandom;
                hi = $urandom;
                if ($signed(lo) > $signed(hi))
                    {lo, hi} = {hi, lo};
            end
            3:
            begin
                lo = $urandom_range(1, 500);
                hi = -$urandom_range(1, 500);
            end
            default:
            begin
                if ($urandom_range(1))
                begin
                    lo = LOWER_LIMIT_RESET;
                    hi = LOWER_LIMIT_RESET + $urandom_range(200);
                end
                else
                begin
                    hi = UPPER_LIMIT_RESET;
                    lo = UPPER_LIMIT_RESET - $urandom_range(200);
                end
            end
        endcase
        case ($urandom_range(3))
            0:       step = 16'd0;
            1:       step = 16'd1;
            2:       step = 16'hFFFF;
            default: step = 16'($urandom);
        endcase
        en = 1'($urandom_range(1));
        case ($urandom_range(5))
            0:       deb = 16'd0;
            1:       deb = 16'hFFFF;
            2:       deb = 16'($urandom);
            default: deb = 16'($urandom_range(1, 4));
        endcase
        apply_settings(lo, hi, step, en, deb);
    endtask

    // Mostly a turning encoder: timestamps that clear the debounce window, a
    // clock that usually toggles and data that follows a spin direction.
    // The rest is bounce inside the window, wild timestamps, arm and set
    // commands and the unused command code.
    task automatic gen_random_cmds(int count);
        logic [TIME_WIDTH-1:0]  delta;
        logic [LIMIT_WIDTH-1:0] target;
        logic                   dat;
        int                     roll;
        for (int n = 0; n < count; n++)
        begin
            roll = $urandom_range(99);
            if (roll < 74)
            begin
                case ($urandom_range(9))
                    0, 1:    delta = $urandom_range(hold_ms);
                    2:       delta = $urandom;
                    default: delta = hold_ms + 1 + $urandom_range(15);
                endcase
                stim_now = stim_now + delta;
                if ($urandom_range(4) != 0)
                    stim_clk = !stim_clk;
                if ($urandom_range(9) == 0)
                    spin_up = !spin_up;
                if ($urandom_range(4) == 0)
                    dat = 1'($urandom_range(1));
                else
                    dat = spin_up ? !stim_clk : stim_clk;
                queue_cmd(CMD_SAMPLE, stim_clk, dat, stim_now, $urandom);
            end
            else if (roll < 84)
                queue_cmd(CMD_ARM, 1'($urandom_range(1)), 1'($urandom_range(1)), $urandom,
                          $urandom);
            else if (roll < 94)
            begin
                // Aim set commands at and just past the limits so saturation
                // is reached often.
                case ($urandom_range(5))
                    0:       target = lim_lo[31:0];
                    1:       target = lim_hi[31:0];
                    2:       target = lim_lo[31:0] - 1;
                    3:       target = lim_hi[31:0] + 1;
                    default: target = $urandom;
                endcase
                queue_cmd(CMD_SET, 1'($urandom_range(1)), 1'($urandom_range(1)), $urandom,
                          target);
            end
            else
                queue_cmd(CMD_UNUSED, 1'($urandom_range(1)), 1'($urandom_range(1)), $urandom,
                          $urandom);
        end
    endtask

    // Hold until every queued beat is taken and every result has come back,
    // then let the result register settle.
    task automatic drain();
        while (encoder_items.size() != 0 || expected_positions.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Driver: predict on every accepted beat, hold an offered beat until it
    // is taken, otherwise offer the next pending one or idle at random.
    always @(posedge clk)
    begin
        if (sample.valid && sample.ready)
            expected_positions.push_back(count_item(encoder_items.pop_front()));
        if (sample.valid && !sample.ready)
            ;
        else if (encoder_items.size() != 0 && $urandom_range(99) >= send_idle_pct)
        begin
            sample.valid        <= 1'b1;
            sample.command      <= encoder_items[0].command;
            sample.clk_level    <= encoder_items[0].clk_level;
            sample.data_level   <= encoder_items[0].data_level;
            sample.time_ms      <= encoder_items[0].time_ms;
            sample.new_position <= encoder_items[0].new_position;
        end
        else
            sample.valid <= 1'b0;
    end

    // Monitor: check each result beat against the oldest prediction, then
    // pick the next ready level. The long hold-off is counted here.
    always @(posedge clk)
    begin
        position_beat_t want;
        if (result.valid && result.ready)
        begin
            if (expected_positions.size() == 0)
            begin
                $display("%0t: unexpected result beat, position %0d movement %0d",
                         $time, result.position, result.movement);
                mismatches++;
            end
            else
            begin
                want = expected_positions.pop_front();
                if (result.position !== want.position)
                begin
                    $display("%0t: position expected %0d actual %0d",
                             $time, want.position, result.position);
                    mismatches++;
                end
                if (result.movement !== want.movement)
                begin
                    $display("%0t: movement expected %0d actual %0d",
                             $time, want.movement, result.movement);
                    mismatches++;
                end
            end
        end
        if (want_long_stall && !long_stall_done)
        begin
            stall_left      = LONG_HOLD_CYCLES;
            long_stall_done = 1'b1;
        end
        if (stall_left > 0)
        begin
            stall_left--;
            result.ready <= 1'b0;
        end
        else
            result.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Watchdog: end a hung run.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("quadrature_encoder_position_counter regression: fail");
            $finish;
        end
    end

    initial
    begin
        // Drive every input to a known level and hold reset.
        rst_n               = 1'b0;
        cfg_write           = 1'b0;
        cfg_index           = REG_LOWER_LIMIT;
        cfg_data            = '0;
        sample.valid        = 1'b0;
        sample.command      = CMD_SAMPLE;
        sample.clk_level    = 1'b0;
        sample.data_level   = 1'b0;
        sample.time_ms      = '0;
        sample.new_position = '0;
        result.ready        = 1'b0;
        send_idle_pct       = 0;
        recv_stall_pct      = 0;
        want_long_stall     = 1'b0;
        long_stall_done     = 1'b0;
        stall_left          = 0;
        mismatches          = 0;
        cycle_count         = 0;

        // Predictor starts from the reset state of the block.
        lim_lo         = longint'($signed(LOWER_LIMIT_RESET));
        lim_hi         = longint'($signed(UPPER_LIMIT_RESET));
        step_size      = STEP_MULT_RESET;
        step_scaled    = 1'b0;
        hold_ms        = DEBOUNCE_RESET;
        track_pos      = 0;
        prev_clk       = 1'b1;
        prev_accept_ms = '0;
        flip_armed     = 1'b0;
        flip_level     = 1'b0;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed, reset registers: a bounce inside the debounce window,
        // single steps both ways, both outcomes of an armed mismatch, set
        // commands at the extremes with no room left to step, the unused
        // command code and a timestamp that wraps.
        queue_cmd(CMD_SAMPLE, 1'b1, 1'b0, 32'd2,  32'd0);
        queue_cmd(CMD_SAMPLE, 1'b0, 1'b1, 32'd3,  32'd0);
        queue_cmd(CMD_SAMPLE, 1'b1, 1'b0, 32'd10, 32'd0);
        queue_cmd(CMD_SAMPLE, 1'b0, 1'b0, 32'd20, 32'd0);
        queue_cmd(CMD_ARM,    1'b1, 1'b0, 32'd0,  32'd0);
        queue_cmd(CMD_SAMPLE, 1'b0, 1'b1, 32'd30, 32'd0);
        queue_cmd(CMD_ARM,    1'b0, 1'b1, 32'd0,  32'd0);
        queue_cmd(CMD_SAMPLE, 1'b1, 1'b1, 32'd40, 32'd0);
        queue_cmd(CMD_SET,    1'b0, 1'b0, 32'd0,  32'h7FFF_FFFF);
        queue_cmd(CMD_SAMPLE, 1'b0, 1'b1, 32'd50, 32'd0);
        queue_cmd(CMD_SET,    1'b1, 1'b1, 32'hFFFF_FFFF, 32'h8000_0000);
        queue_cmd(CMD_SAMPLE, 1'b1, 1'b1, 32'd60, 32'hFFFF_FFFF);
        queue_cmd(CMD_UNUSED, 1'b1, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        queue_cmd(CMD_SAMPLE, 1'b0, 1'b1, 32'hFFFF_FFFF, 32'd0);
        queue_cmd(CMD_SAMPLE, 1'b1, 1'b0, 32'd5, 32'd0);
        drain();

        // Directed, large multiplier in a narrow range: saturate both ways,
        // then a sample at the same millisecond with zero debounce.
        apply_settings(-32'd100, 32'd100, 16'hFFFF, 1'b1, 16'd0);
        queue_cmd(CMD_SET,    1'b0, 1'b0, 32'd0,   32'd0);
        queue_cmd(CMD_SAMPLE, 1'b0, 1'b1, 32'd100, 32'd0);
        queue_cmd(CMD_SAMPLE, 1'b1, 1'b1, 32'd101, 32'd0);
        queue_cmd(CMD_SAMPLE, 1'b0, 1'b1, 32'd101, 32'd0);
        drain();

        // Directed, crossed limits with a zero step: stepping down from below
        // the lower limit lands on the lower one and reports up, stepping up
        // from above the upper limit lands on the upper one and reports down.
        apply_settings(32'd50, -32'd50, 16'd0, 1'b1, 16'd0);
        queue_cmd(CMD_SAMPLE, 1'b0, 1'b0, 32'd200, 32'd0);
        queue_cmd(CMD_SAMPLE, 1'b1, 1'b0, 32'd210, 32'd0);
        queue_cmd(CMD_SET,    1'b0, 1'b0, 32'd0,   32'd0);
        queue_cmd(CMD_SAMPLE, 1'b0, 1'b1, 32'd220, 32'd0);
        drain();

        // Random phases: rotate through no idling, a mostly idle sender, a
        // mostly stalling receiver and both idling. Each phase runs under a
        // fresh setting, in two halves that each end once every result is back.
        stim_now = $urandom;
        stim_clk = prev_clk;
        spin_up  = 1'($urandom_range(1));
        for (int ph = 0; ph < 8; ph++)
        begin
            case (ph % 4)
                0:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct  = 82;
                    recv_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 82;
                end
                default:
                begin
                    send_idle_pct  = 22;
                    recv_stall_pct = 22;
                end
            endcase
            pick_random_settings();
            gen_random_cmds(22);
            drain();
            gen_random_cmds(23);
            drain();
        end

        // Back pressure: the receiver holds off for a long stretch while the
        // sender keeps offering, so the result register fills and the block
        // drops ready on its input.
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        pick_random_settings();
        want_long_stall <= 1'b1;
        gen_random_cmds(25);
        drain();

        if (mismatches == 0)
            $display("quadrature_encoder_position_counter regression: pass");
        else
            $display("quadrature_encoder_position_counter regression: fail");
        $finish;
    end

endmodule

// File: filelist.f
+incdir+hdl
hdl/qepc_pkg.sv
hdl/qepc_if.sv
hdl/quadrature_encoder_position_counter.sv
verif/quadrature_encoder_position_counter_test.sv
